// ===== rtl/sorted_priority_queue_assert.svh =====
// Assertion macros for the sorted priority queue RTL.
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPQ_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/spq_pkg.sv =====
// Types and constants of the sorted priority queue.
`default_nettype none
package spq_pkg;

  localparam int ValueWidth = 32;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  localparam logic [1:0] STATUS_DONE      = 2'd0;
  localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY     = 2'd2;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_APPLY,
    ST_REPORT
  } state_t;

  typedef struct packed {
    logic                         valid;
    logic                         le;
    logic signed [ValueWidth-1:0] data;
  } cell_link_t;

  typedef struct packed {
    logic                         capture;
    logic                         ins;
    logic                         del;
    logic signed [ValueWidth-1:0] value;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/spq_cell.sv =====
// One storage cell of the queue: an entry, its valid bit and its compare flags.
`default_nettype none
module spq_cell
  import spq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cell_ctrl_t ctrl,
  input  wire cell_link_t left,
  input  wire cell_link_t right,
  output cell_link_t      link,
  output logic            eq
);

  logic signed [ValueWidth-1:0] data;
  logic signed [ValueWidth-1:0] data_next;
  logic                         valid;
  logic                         valid_next;
  logic                         le_q;
  logic                         eq_q;

  always_comb begin
    data_next  = data;
    valid_next = valid;
    if (ctrl.ins && le_q && left.valid) begin
      data_next  = left.le ? left.data : ctrl.value;
      valid_next = 1'b1;
    end else if (ctrl.del && valid && le_q) begin
      data_next  = right.data;
      valid_next = right.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
    data <= data_next;
    if (ctrl.capture) begin
      le_q <= !valid || (ctrl.value >= data);
      eq_q <= valid && (ctrl.value == data);
    end
  end

  assign link = '{valid: valid, le: le_q, data: data};
  assign eq   = eq_q;

endmodule
`default_nettype wire

// ===== rtl/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: control, cell chain and result register.
// Each operation passes through ST_IDLE, ST_APPLY and ST_REPORT. The edge that accepts the
// input word also registers every cell's compare flags against the new value; in ST_APPLY
// the cells at and behind the insert or delete point shift or load, and at the end of
// ST_REPORT the result register is loaded from the head cell and the fill counter, and the
// result word is offered. The next input word is accepted only back in ST_IDLE, once the
// result register is free or is being read, so a word is through before the next enters.
// Values are held in descending order; inserts go ahead of equal entries and deletes remove
// the frontmost equal entry. No clearing is needed after reset.
`default_nettype none
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,  // value[31:0]
  input  wire logic        s_tuser,  // op[0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata   // status[1:0], count[5:2], head_value[37:6],
                                     // head_valid[38], zero[39]
);

  `include "sorted_priority_queue_assert.svh"

  localparam int CW = $clog2(DEPTH + 1);

  state_t                       state;
  state_t                       state_next;
  logic                         op;
  logic signed [ValueWidth-1:0] value;
  logic [1:0]                   status;
  logic [1:0]                   status_next;
  logic [CW-1:0]                fill;
  logic [CW-1:0]                fill_next;
  logic [CW+3:0]                fill_ext;
  logic [39:0]                  result;

  cell_ctrl_t                   ctrl;
  cell_link_t                   links [DEPTH];
  logic [DEPTH-1:0]             eqs;
  logic                         found;
  logic                         full;
  logic                         empty;
  logic                         accept;

  assign s_tready = (state == ST_IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;
  assign found    = |eqs;
  assign full     = links[DEPTH-1].valid;
  assign empty    = !links[0].valid;

  always_comb begin
    state_next   = state;
    status_next  = status;
    fill_next    = fill;
    ctrl.capture = 1'b0;
    ctrl.ins     = 1'b0;
    ctrl.del     = 1'b0;
    ctrl.value   = value;
    unique case (state)
      ST_IDLE: begin
        ctrl.value   = s_tdata;
        ctrl.capture = accept;
        if (accept) begin
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: begin
        state_next = ST_REPORT;
        if (op == OP_INSERT) begin
          if (full) begin
            status_next = STATUS_OVERFLOW;
          end else begin
            status_next = STATUS_DONE;
            ctrl.ins    = 1'b1;
            fill_next   = fill + CW'(1);
          end
        end else begin
          if (empty) begin
            status_next = STATUS_EMPTY;
          end else if (!found) begin
            status_next = STATUS_NOT_FOUND;
          end else begin
            status_next = STATUS_DONE;
            ctrl.del    = 1'b1;
            fill_next   = fill - CW'(1);
          end
        end
      end
      ST_REPORT: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    cell_link_t left_in;
    cell_link_t right_in;
    if (k == 0) begin : g_first
      assign left_in = '{valid: 1'b1, le: 1'b0, data: '0};
    end else begin : g_left
      assign left_in = links[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign right_in = '{valid: 1'b0, le: 1'b0, data: '0};
    end else begin : g_right
      assign right_in = links[k+1];
    end
    spq_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctrl  (ctrl),
      .left  (left_in),
      .right (right_in),
      .link  (links[k]),
      .eq    (eqs[k])
    );
  end

  assign fill_ext = {4'b0, fill};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      fill     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      if (state == ST_REPORT) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
    status <= status_next;
    if (accept) begin
      op    <= s_tuser;
      value <= s_tdata;
    end
    if (state == ST_REPORT) begin
      result <= {1'b0, links[0].valid,
                 links[0].valid ? links[0].data : {ValueWidth{1'b0}},
                 fill_ext[3:0], status};
    end
  end

  assign m_tdata = result;

  `SPQ_ASSERT_NOW(a_ready_only_idle, s_tready, state == ST_IDLE, "input ready outside idle")
  `SPQ_ASSERT_NEXT(a_result_src, !m_tvalid && state != ST_REPORT, !m_tvalid, "stray result")
  `SPQ_ASSERT_NOW(a_fill_bound, 1'b1, fill <= CW'(DEPTH), "fill count above depth")
  `SPQ_ASSERT_NOW(a_head_fill, 1'b1, links[0].valid == (fill != '0), "head valid vs fill")

endmodule
`default_nettype wire
